// File: rtl/core/radc_pkg.sv
// ----------------------------------------------------------------------------
// radc_pkg - shared types and constants for the address derive/check block
// CRC-32 column table, salts, tweaks and the per-record check status.
// ----------------------------------------------------------------------------
package radc_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W   = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION = 1'd1;
  localparam int unsigned CFG_DATA_W  = 32;

  // record body: 4 magic bytes, 1 version byte, 16 random bytes
  localparam int unsigned RAND_BYTES  = 16;
  localparam int unsigned BODY_BYTES  = 5 + RAND_BYTES;
  localparam int unsigned POS_W       = $clog2(BODY_BYTES);

  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;

  localparam logic [7:0]  SUB_ZERO    = 8'h5A;
  localparam logic [7:0]  SUB_ONES    = 8'hA5;
  localparam logic [7:0]  LAST_XOR    = 8'h3C;
  localparam logic [7:0]  TWEAK_B0    = 8'h5E;
  localparam logic [7:0]  TWEAK_B1    = 8'hA1;
  localparam logic [7:0]  TWEAK_PF    = 8'h3C;
  localparam logic [7:0]  CHAN_SALT   = 8'h2B;
  localparam logic [7:0]  CHAN_SPAN   = 8'd71;
  localparam logic [6:0]  CHAN_BASE   = 7'd10;

  localparam logic [7:0] SALT_B0 [4] = '{8'h53, 8'hC1, 8'h97, 8'h2D};
  localparam logic [7:0] SALT_B1 [4] = '{8'hA4, 8'h6E, 8'h39, 8'hD2};
  localparam logic [7:0] SALT_PF [8] = '{8'h11, 8'h3D, 8'h57, 8'h7B,
                                         8'h91, 8'hB5, 8'hD7, 8'hE9};

  typedef logic [31:0] crc_tab_t [BODY_BYTES*8];

  // per-record check status handed from the lane stage to the merge
  typedef struct packed {
    logic        magic_ok;
    logic        version_ok;
    logic [31:0] crc_calc;
    logic [31:0] crc_check;
  } rec_chk_t;

  // bitwise reflected CRC steps, used at elaboration only
  function automatic logic [31:0] crc_run(logic [31:0] c, int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // effect of each body bit on the final register (linear part only)
  function automatic crc_tab_t crc_table();
    crc_tab_t t;
    for (int unsigned p = 0; p < BODY_BYTES; p++) begin
      for (int unsigned b = 0; b < 8; b++) begin
        t[p*8+b] = crc_run(32'd1 << b, 8 * (BODY_BYTES - p));
      end
    end
    return t;
  endfunction

  localparam crc_tab_t    CRC_TAB  = crc_table();
  // init value run over an all-zero body, with the final inversion folded in
  localparam logic [31:0] CRC_BASE = ~crc_run(CRC_INIT, 8 * BODY_BYTES);

endpackage

// File: rtl/core/radio_address_derive_check.sv
// ----------------------------------------------------------------------------
// radio_address_derive_check - identity record check and address derivation
// Two-stage lane/merge pipeline with valid/ready words on both sides.
// ----------------------------------------------------------------------------
// One input word is one identity record. It is accepted when magic and
// version match the configured registers and the stored CRC-32 (reflected,
// poly 0xEDB88320) matches the one computed over the 21-byte body; then two
// base addresses, eight prefixes and a channel of 10..80 are derived, else
// the result word has valid_res=0 and all fields zero. Throughput is one
// word per cycle while out_ready does not stall the output. Two register
// stages, the lane register and the output register: an accepted word is
// held in the lane register and goes through the merge into the output
// register, which holds the result word until taken. Each CRC lane folds
// one body byte through a constant column table, each mix lane makes one
// address byte, the lane stage XORs the CRC lanes, and the merge checks the
// record and applies the group tweaks. in_ready depends combinationally on
// out_ready. Write configuration only while the pipeline is empty.
// ----------------------------------------------------------------------------
module radio_address_derive_check (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_we,
  input  logic [radc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [radc_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input words
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [31:0]                       rec_magic,
  input  logic [7:0]                        rec_version,
  input  logic [63:0]                       random_low,
  input  logic [63:0]                       random_high,
  input  logic [31:0]                       rec_check,
  // result words
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              valid_res,
  output logic [31:0]                       base_addr0,
  output logic [31:0]                       base_addr1,
  output logic [63:0]                       prefix_bytes,
  output logic [6:0]                        chan_num
);
  import radc_pkg::*;

  // config registers
  logic [31:0] expected_magic;
  logic [7:0]  expected_version;

  // body bytes in CRC order and random bytes
  logic [7:0]  body   [BODY_BYTES];
  logic [7:0]  rnd    [RAND_BYTES];
  logic [31:0] contrib[BODY_BYTES];
  logic [31:0] crc_sum;

  // mix lane outputs
  logic [7:0]  mix_b0 [4];
  logic [7:0]  mix_b1 [4];
  logic [7:0]  mix_pf [8];

  // stage 1 (lane results)
  logic        s1_valid;
  rec_chk_t    s1_chk;
  rec_chk_t    chk_next;
  logic [31:0] s1_b0;
  logic [31:0] s1_b1;
  logic [63:0] s1_pf;
  logic [7:0]  s1_chan;

  // merge outputs
  logic        m_ok;
  logic [31:0] m_base0;
  logic [31:0] m_base1;
  logic [63:0] m_prefix;
  logic [6:0]  m_chan;

  logic        out_adv;
  logic        in_acc;

  // Configuration writes; only two registers so every index is decoded.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic   <= '0;
      expected_version <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAGIC:   expected_magic   <= cfg_data;
        REG_VERSION: expected_version <= cfg_data[7:0];
        default:     ;
      endcase
    end
  end

  // Pipeline flow: output register moves when empty or taken,
  // lane stage moves when empty or draining into the output.
  assign out_adv  = !out_valid || out_ready;
  assign in_ready = !s1_valid || out_adv;
  assign in_acc   = in_valid && in_ready;

  // Split the record into bytes: magic little-endian, version, random 0..15.
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      rnd[k]   = random_low[8*k +: 8];
      rnd[k+8] = random_high[8*k +: 8];
    end
    for (int k = 0; k < 4; k++) begin
      body[k] = rec_magic[8*k +: 8];
    end
    body[4] = rec_version;
    for (int k = 0; k < RAND_BYTES; k++) begin
      body[5+k] = rnd[k];
    end
  end

  // CRC lanes: one per body byte, each contributes independently.
  for (genvar g = 0; g < BODY_BYTES; g++) begin : g_crc
    radc_crc_lane u_crc (
      .pos     (POS_W'(g)),
      .data    (body[g]),
      .contrib (contrib[g])
    );
  end

  always_comb begin
    crc_sum = CRC_BASE;
    for (int k = 0; k < BODY_BYTES; k++) begin
      crc_sum = crc_sum ^ contrib[k];
    end
  end

  // Mix lanes: base address 0, base address 1, prefixes.
  for (genvar g = 0; g < 4; g++) begin : g_base
    radc_mix_lane u_b0 (
      .a     (rnd[g]),
      .b     (rnd[g+8]),
      .salt  (SALT_B0[g]),
      .mixed (mix_b0[g])
    );
    radc_mix_lane u_b1 (
      .a     (rnd[g+4]),
      .b     (rnd[g+12]),
      .salt  (SALT_B1[g]),
      .mixed (mix_b1[g])
    );
  end

  for (genvar g = 0; g < 8; g++) begin : g_pf
    radc_mix_lane u_pf (
      .a     (rnd[g]),
      .b     (rnd[(g+5)%RAND_BYTES]),
      .salt  (SALT_PF[g]),
      .mixed (mix_pf[g])
    );
  end

  always_comb begin
    chk_next.magic_ok   = (rec_magic == expected_magic);
    chk_next.version_ok = (rec_version == expected_version);
    chk_next.crc_calc   = crc_sum;
    chk_next.crc_check  = rec_check;
  end

  // Lane stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_chk  <= chk_next;
      s1_b0   <= {mix_b0[3], mix_b0[2], mix_b0[1], mix_b0[0]};
      s1_b1   <= {mix_b1[3], mix_b1[2], mix_b1[1], mix_b1[0]};
      s1_pf   <= {mix_pf[7], mix_pf[6], mix_pf[5], mix_pf[4],
                  mix_pf[3], mix_pf[2], mix_pf[1], mix_pf[0]};
      s1_chan <= rnd[1] ^ rnd[14] ^ CHAN_SALT;
    end
  end

  radc_merge u_merge (
    .chk      (s1_chk),
    .b0_raw   (s1_b0),
    .b1_raw   (s1_b1),
    .pf_raw   (s1_pf),
    .chan_raw (s1_chan),
    .rec_ok   (m_ok),
    .base0    (m_base0),
    .base1    (m_base1),
    .prefix   (m_prefix),
    .chan     (m_chan)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid) begin
      valid_res    <= m_ok;
      base_addr0   <= m_base0;
      base_addr1   <= m_base1;
      prefix_bytes <= m_prefix;
      chan_num     <= m_chan;
    end
  end

  // A rejected record carries all-zero fields.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |->
      base_addr0 == '0 && base_addr1 == '0 && prefix_bytes == '0 && chan_num == '0)
    else $error("rejected record with nonzero fields");

  // An accepted record always gets a channel in 10..80.
  a_chan_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_res |-> chan_num >= 7'd10 && chan_num <= 7'd80)
    else $error("derived channel out of range");

  // Input back-pressure only when both stages hold a word.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input stalled with room in the pipeline");

  // A word in the lane stage that cannot drain is still there next cycle.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_adv |=> s1_valid)
    else $error("lane stage word lost under stall");

endmodule

// File: rtl/core/radc_crc_lane.sv
// ----------------------------------------------------------------------------
// radc_crc_lane - CRC contribution of one body byte
// XOR of the table columns selected by the byte's set bits.
// ----------------------------------------------------------------------------
module radc_crc_lane (
  input  logic [radc_pkg::POS_W-1:0] pos,
  input  logic [7:0]                 data,
  output logic [31:0]                contrib
);
  import radc_pkg::*;

  always_comb begin
    contrib = '0;
    for (int b = 0; b < 8; b++) begin
      contrib = contrib ^ ({32{data[b]}} & CRC_TAB[{pos, 3'(b)}]);
    end
  end

endmodule

// File: rtl/core/radc_mix_lane.sv
// ----------------------------------------------------------------------------
// radc_mix_lane - one derived address byte
// a ^ rotl1(b) ^ salt, with substitutes for all-zero and all-one bytes.
// ----------------------------------------------------------------------------
module radc_mix_lane (
  input  logic [7:0] a,
  input  logic [7:0] b,
  input  logic [7:0] salt,
  output logic [7:0] mixed
);
  import radc_pkg::*;

  logic [7:0] raw;

  assign raw = a ^ {b[6:0], b[7]} ^ salt;

  always_comb begin
    priority if (raw == 8'h00) begin
      mixed = salt ^ SUB_ZERO;
    end else if (raw == 8'hFF) begin
      mixed = salt ^ SUB_ONES;
    end else begin
      mixed = raw;
    end
  end

endmodule

// File: rtl/core/radc_merge.sv
// ----------------------------------------------------------------------------
// radc_merge - combine lane results into one result word
// Record check, trivial-group tweak, channel reduction and reject masking.
// ----------------------------------------------------------------------------
module radc_merge (
  input  radc_pkg::rec_chk_t chk,
  input  logic [31:0]        b0_raw,
  input  logic [31:0]        b1_raw,
  input  logic [63:0]        pf_raw,
  input  logic [7:0]         chan_raw,
  output logic               rec_ok,
  output logic [31:0]        base0,
  output logic [31:0]        base1,
  output logic [63:0]        prefix,
  output logic [6:0]         chan
);
  import radc_pkg::*;

  logic [31:0] b0_fix;
  logic [31:0] b1_fix;
  logic [63:0] pf_fix;
  logic [7:0]  chan_mod;

  function automatic logic [31:0] fix32(logic [31:0] g, logic [7:0] tw);
    if (g == '0 || g == '1) begin
      g[7:0]   = g[7:0] ^ tw;
      g[31:24] = g[31:24] ^ tw ^ LAST_XOR;
    end
    return g;
  endfunction

  function automatic logic [63:0] fix64(logic [63:0] g, logic [7:0] tw);
    if (g == '0 || g == '1) begin
      g[7:0]   = g[7:0] ^ tw;
      g[63:56] = g[63:56] ^ tw ^ LAST_XOR;
    end
    return g;
  endfunction

  assign rec_ok = chk.magic_ok && chk.version_ok && (chk.crc_calc == chk.crc_check);

  assign b0_fix = fix32(b0_raw, TWEAK_B0);
  assign b1_fix = fix32(b1_raw, TWEAK_B1);
  assign pf_fix = fix64(pf_raw, TWEAK_PF);

  // byte mod 71: at most three subtractions
  always_comb begin
    priority if (chan_raw >= 8'(3 * CHAN_SPAN)) begin
      chan_mod = chan_raw - 8'(3 * CHAN_SPAN);
    end else if (chan_raw >= 8'(2 * CHAN_SPAN)) begin
      chan_mod = chan_raw - 8'(2 * CHAN_SPAN);
    end else if (chan_raw >= CHAN_SPAN) begin
      chan_mod = chan_raw - CHAN_SPAN;
    end else begin
      chan_mod = chan_raw;
    end
  end

  assign base0  = rec_ok ? b0_fix : '0;
  assign base1  = rec_ok ? b1_fix : '0;
  assign prefix = rec_ok ? pf_fix : '0;
  assign chan   = rec_ok ? (CHAN_BASE + chan_mod[6:0]) : '0;

endmodule
